>>> src/utf8n_pkg.sv
// shared types and constants for the utf8 text normalizer
package utf8n_pkg;

    // field widths
    localparam int BYTE_W       = 8;
    localparam int CHAR_LIMIT_W = 8;
    localparam int BYTE_CAP_W   = 10;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;

    // most data bytes one request can produce: a space plus a four byte character
    localparam int DATA_MAX = 5;
    localparam int COUNT_W  = 3;

    // register defaults and text buffer size
    localparam int unsigned MAX_TEXT_BYTES_DEF  = 512;
    localparam logic [CHAR_LIMIT_W-1:0] CHAR_LIMIT_RST = 8'd128;
    localparam logic [BYTE_CAP_W-1:0]   BYTE_CAP_RST   = 10'd512;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHAR_LIMIT    = 2'd0,
        REG_BYTE_CAPACITY = 2'd1
    } cfg_reg_t;

    // final status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_SHORT   = 2'd2
    } status_t;

    // one input request
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } in_item_t;

    // one output request
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_status;
        logic [1:0]        status;
        logic              out_last;
    } out_item_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [DATA_MAX-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]              ndata;
        logic                            has_status;
        status_t                         status;
    } bundle_t;

endpackage

>>> src/utf8n_core.sv
// utf8 decoder, whitespace folding and limit tracking, one byte per cycle while adv is high
module utf8n_core
    import utf8n_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  in_item_t                item,
    input  logic [CHAR_LIMIT_W-1:0] char_limit,
    input  logic [BYTE_CAP_W-1:0]   byte_capacity,
    output bundle_t                 bundle
);

    localparam int MAXB_W = $clog2(MAX_TEXT_BYTES + 1);
    localparam int CAP_W  = (MAXB_W > BYTE_CAP_W) ? MAXB_W : BYTE_CAP_W;
    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_TEXT_BYTES);

    // per-string state
    logic [BYTE_W-1:0]       seq0_reg, seq0_next;
    logic [BYTE_W-1:0]       seq1_reg, seq1_next;
    logic [BYTE_W-1:0]       seq2_reg, seq2_next;
    logic [2:0]              have_reg, have_next;
    logic [2:0]              need_reg, need_next;
    logic                    pend_reg, pend_next;
    logic [BYTE_CAP_W-1:0]   kept_reg, kept_next;
    logic [CHAR_LIMIT_W-1:0] chars_reg, chars_next;
    logic                    stopped_reg, stopped_next;
    logic                    failed_reg, failed_next;

    // decode and take-char intermediates
    logic [BYTE_W-1:0]          b;
    logic [CAP_W-1:0]           cap;
    logic                       char_ok;
    logic [20:0]                cp;
    logic [2:0]                 width;
    logic [3:0][BYTE_W-1:0]     char_bytes;
    logic                       is_ctrl, is_ws_ctrl, is_space;
    logic                       space_stop;
    logic                       nsp;
    logic [BYTE_CAP_W-1:0]      k1;
    logic [CHAR_LIMIT_W-1:0]    c1;
    logic [CAP_W:0]             sum_space, sum_char;

    assign b = item.in_byte;

    // effective capacity, clamped to the text buffer size
    assign cap = (CAP_W'(byte_capacity) > MAX_CAP) ? MAX_CAP : CAP_W'(byte_capacity);

    // character classes
    assign is_ctrl    = (cp < 21'h20) || (cp >= 21'h7f && cp <= 21'h9f);
    assign is_ws_ctrl = (cp == 21'h09) || (cp == 21'h0a) || (cp == 21'h0d) || (cp == 21'h85);
    assign is_space   = (cp == 21'h20) || (cp == 21'h00a0) || (cp == 21'h1680) ||
                        (cp >= 21'h2000 && cp <= 21'h200a) || (cp == 21'h2028) ||
                        (cp == 21'h2029) || (cp == 21'h202f) || (cp == 21'h205f) ||
                        (cp == 21'h3000);

    // limit sums
    assign sum_space = {1'b0, CAP_W'(kept_reg)} + (CAP_W + 1)'(1);
    assign sum_char  = {1'b0, CAP_W'(k1)} + (CAP_W + 1)'(width);

    always_comb
    begin
        seq0_next    = seq0_reg;
        seq1_next    = seq1_reg;
        seq2_next    = seq2_reg;
        have_next    = have_reg;
        need_next    = need_reg;
        pend_next    = pend_reg;
        kept_next    = kept_reg;
        chars_next   = chars_reg;
        stopped_next = stopped_reg;
        failed_next  = failed_reg;
        bundle       = '0;
        char_ok      = 1'b0;
        cp           = '0;
        width        = 3'd1;
        char_bytes   = '0;
        space_stop   = 1'b0;
        nsp          = 1'b0;
        k1           = kept_reg;
        c1           = chars_reg;

        // byte decoding
        if (!failed_reg && !stopped_reg)
        begin
            if (need_reg == 3'd0 || have_reg == 3'd0)
            begin
                seq0_next = b;
                have_next = 3'd1;
                if (b < 8'h80)
                begin
                    need_next     = 3'd0;
                    have_next     = 3'd0;
                    char_ok       = 1'b1;
                    cp            = {13'd0, b};
                    width         = 3'd1;
                    char_bytes[0] = b;
                end
                else if (b >= 8'hc2 && b <= 8'hdf)
                begin
                    need_next = 3'd1;
                end
                else if (b >= 8'he0 && b <= 8'hef)
                begin
                    need_next = 3'd2;
                end
                else if (b >= 8'hf0 && b <= 8'hf4)
                begin
                    need_next = 3'd3;
                end
                else
                begin
                    failed_next = 1'b1;
                    have_next   = 3'd0;
                    need_next   = 3'd0;
                end
            end
            else if (b[7:6] != 2'b10)
            begin
                failed_next = 1'b1;
                have_next   = 3'd0;
                need_next   = 3'd0;
            end
            else
            begin
                if (have_reg == 3'd1)
                begin
                    seq1_next = b;
                end
                else if (have_reg == 3'd2)
                begin
                    seq2_next = b;
                end
                have_next = have_reg + 3'd1;
                // sequence complete
                if (have_reg == need_reg)
                begin
                    have_next = 3'd0;
                    need_next = 3'd0;
                    width     = need_reg + 3'd1;
                    unique case (need_reg)
                        3'd1:
                        begin
                            cp            = {10'd0, seq0_reg[4:0], b[5:0]};
                            char_bytes[0] = seq0_reg;
                            char_bytes[1] = b;
                        end
                        3'd2:
                        begin
                            cp            = {5'd0, seq0_reg[3:0], seq1_reg[5:0], b[5:0]};
                            char_bytes[0] = seq0_reg;
                            char_bytes[1] = seq1_reg;
                            char_bytes[2] = b;
                        end
                        default:
                        begin
                            cp = {seq0_reg[2:0], seq1_reg[5:0], seq2_reg[5:0], b[5:0]};
                            char_bytes[0] = seq0_reg;
                            char_bytes[1] = seq1_reg;
                            char_bytes[2] = seq2_reg;
                            char_bytes[3] = b;
                        end
                    endcase
                    // overlong, surrogate or out of range
                    if ((seq0_reg == 8'he0 && cp < 21'h800) ||
                        (seq0_reg == 8'hed && cp >= 21'hd800) ||
                        (seq0_reg == 8'hf0 && cp < 21'h10000) ||
                        (cp > 21'h10ffff))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        char_ok = 1'b1;
                    end
                end
            end
        end

        // whitespace folding and limits for a finished character
        if (char_ok)
        begin
            if (is_ctrl)
            begin
                if (is_ws_ctrl)
                begin
                    pend_next = kept_reg != '0;
                end
            end
            else if (is_space)
            begin
                pend_next = kept_reg != '0;
            end
            else
            begin
                if (pend_reg && kept_reg != '0)
                begin
                    if (chars_reg >= char_limit || sum_space >= {1'b0, cap})
                    begin
                        stopped_next = 1'b1;
                        space_stop   = 1'b1;
                    end
                    else
                    begin
                        nsp             = 1'b1;
                        bundle.bytes[0] = 8'h20;
                        k1              = kept_reg + BYTE_CAP_W'(1);
                        c1              = chars_reg + CHAR_LIMIT_W'(1);
                    end
                end
                if (!space_stop)
                begin
                    pend_next    = 1'b0;
                    kept_next    = k1;
                    chars_next   = c1;
                    bundle.ndata = COUNT_W'(nsp);
                    if (c1 >= char_limit || sum_char >= {1'b0, cap})
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (i < int'(width))
                            begin
                                if (nsp)
                                begin
                                    bundle.bytes[i + 1] = char_bytes[i];
                                end
                                else
                                begin
                                    bundle.bytes[i] = char_bytes[i];
                                end
                            end
                        end
                        kept_next    = k1 + BYTE_CAP_W'(width);
                        chars_next   = c1 + CHAR_LIMIT_W'(1);
                        bundle.ndata = COUNT_W'(nsp) + width;
                    end
                end
            end
        end

        // end of string: status and per-string clear
        if (item.in_last)
        begin
            if (!failed_next && !stopped_next && have_next != 3'd0)
            begin
                failed_next = 1'b1;
            end
            bundle.has_status = 1'b1;
            if (failed_next)
            begin
                bundle.status = STATUS_INVALID;
            end
            else if (chars_next >= CHAR_LIMIT_W'(2))
            begin
                bundle.status = STATUS_OK;
            end
            else
            begin
                bundle.status = STATUS_SHORT;
            end
            have_next    = 3'd0;
            need_next    = 3'd0;
            pend_next    = 1'b1;
            kept_next    = '0;
            chars_next   = '0;
            stopped_next = 1'b0;
            failed_next  = 1'b0;
        end
    end

    // sequence byte store, no reset needed
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seq0_reg <= seq0_next;
            seq1_reg <= seq1_next;
            seq2_reg <= seq2_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg    <= 3'd0;
            need_reg    <= 3'd0;
            pend_reg    <= 1'b1;
            kept_reg    <= '0;
            chars_reg   <= '0;
            stopped_reg <= 1'b0;
            failed_reg  <= 1'b0;
        end
        else if (adv)
        begin
            have_reg    <= have_next;
            need_reg    <= need_next;
            pend_reg    <= pend_next;
            kept_reg    <= kept_next;
            chars_reg   <= chars_next;
            stopped_reg <= stopped_next;
            failed_reg  <= failed_next;
        end
    end

endmodule

>>> src/utf8n_serializer.sv
// result register that hands out a bundle one request per cycle while out_stall is low
module utf8n_serializer
    import utf8n_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  bundle_t   bundle,
    output logic      load_ready,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    bundle_t            bundle_reg;
    logic               busy_reg, busy_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] total, new_total;
    logic               take, at_end;

    assign total     = bundle_reg.ndata + COUNT_W'(bundle_reg.has_status);
    assign new_total = bundle.ndata + COUNT_W'(bundle.has_status);
    assign take      = busy_reg && !out_stall;
    assign at_end    = (idx_reg + COUNT_W'(1)) == total;

    // a new bundle may enter when empty or when the last request leaves now
    assign load_ready = !busy_reg || (take && at_end);
    assign out_valid  = busy_reg;

    // current output request
    always_comb
    begin
        out_data = '0;
        if (idx_reg < bundle_reg.ndata)
        begin
            out_data.out_byte = bundle_reg.bytes[idx_reg];
        end
        else
        begin
            out_data.is_status = 1'b1;
            out_data.status    = bundle_reg.status;
            out_data.out_last  = 1'b1;
        end
    end

    // entry pointer and busy flag
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + COUNT_W'(1);
            end
        end
        if (load)
        begin
            busy_next = new_total != '0;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // bundle payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bundle_reg <= bundle;
        end
    end

endmodule

>>> src/utf8_text_normalizer.sv
// top level: input register, configuration registers, decoder and output serializer
// an accepted byte goes to the input register, and its results to the result register
// in the output serializer; throughput: 1 byte per cycle while each byte yields at most
// one result and out_stall is low; more results from a byte hold the input back
// reset: asynchronous active low; char_limit 128, byte_capacity 512, string state clear
module utf8_text_normalizer
    import utf8n_pkg::*;
#(
    parameter int unsigned MAX_TEXT_BYTES = MAX_TEXT_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                    in_valid_reg, in_valid_next;
    in_item_t                in_data_reg;
    logic [CHAR_LIMIT_W-1:0] char_limit_reg;
    logic [BYTE_CAP_W-1:0]   byte_cap_reg;
    logic                    adv, load_ready, accept;
    bundle_t                 bundle;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign adv           = in_valid_reg && load_ready;
    assign in_stall      = in_valid_reg && !load_ready;
    assign accept        = in_valid && !in_stall;
    assign in_valid_next = accept ? 1'b1 : (adv ? 1'b0 : in_valid_reg);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_limit_reg <= CHAR_LIMIT_RST;
            byte_cap_reg   <= BYTE_CAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CHAR_LIMIT)
            begin
                char_limit_reg <= cfg_data[CHAR_LIMIT_W-1:0];
            end
            else if (cfg_index == REG_BYTE_CAPACITY)
            begin
                byte_cap_reg <= cfg_data[BYTE_CAP_W-1:0];
            end
        end
    end

    // decoder and string state
    utf8n_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .item          (in_data_reg),
        .char_limit    (char_limit_reg),
        .byte_capacity (byte_cap_reg),
        .bundle        (bundle)
    );

    // result register and output
    utf8n_serializer u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (adv),
        .bundle     (bundle),
        .load_ready (load_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

>>> tb/utf8n_text_checker.sv
// checker for the utf8 text normalizer: predicts normalized text and status, compares output
module utf8n_text_checker
    import utf8n_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  in_item_t               in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  out_item_t              out_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     text_backlog,
    output int                     strings_done,
    output int                     bytes_in,
    output int                     bytes_out,
    output int                     ok_count,
    output int                     invalid_count,
    output int                     short_count
);

    // register copies
    logic [CHAR_LIMIT_W-1:0] lim_chars;
    logic [BYTE_CAP_W-1:0]   lim_bytes;

    // per-string decoder and collapse state
    logic [BYTE_W-1:0] seq_buf [4];
    int unsigned       seq_have;
    int unsigned       seq_need;
    bit                pend_space;
    int unsigned       kept_bytes;
    int unsigned       kept_chars;
    bit                stopped;
    bit                failed;

    // normalized text and status still owed by the block
    out_item_t norm_text_q [$];
    out_item_t want;

    function automatic void clear_text_state();
        seq_buf    = '{default: '0};
        seq_have   = 0;
        seq_need   = 0;
        pend_space = 1'b1;
        kept_bytes = 0;
        kept_chars = 0;
        stopped    = 1'b0;
        failed     = 1'b0;
    endfunction

    function automatic bit is_text_space(int unsigned cp);
        return cp == 'h20 || cp == 'h00a0 || cp == 'h1680 ||
               (cp >= 'h2000 && cp <= 'h200a) || cp == 'h2028 ||
               cp == 'h2029 || cp == 'h202f || cp == 'h205f || cp == 'h3000;
    endfunction

    function automatic void owe_byte(logic [BYTE_W-1:0] b);
        out_item_t item;
        item.out_byte  = b;
        item.is_status = 1'b0;
        item.status    = STATUS_OK;
        item.out_last  = 1'b0;
        norm_text_q.push_back(item);
    endfunction

    // one complete valid character: drop, collapse or keep it
    function automatic void keep_char(int unsigned cp, int unsigned width);
        int unsigned cap;
        int unsigned i;
        cap = lim_bytes;
        if (cap > MAX_TEXT_BYTES_DEF)
            cap = MAX_TEXT_BYTES_DEF;
        // control characters, where tab, lf, cr and nel act as whitespace
        if (cp < 'h20 || (cp >= 'h7f && cp <= 'h9f)) begin
            if (cp == 'h09 || cp == 'h0a || cp == 'h0d || cp == 'h85)
                pend_space = kept_bytes != 0;
            return;
        end
        if (is_text_space(cp)) begin
            pend_space = kept_bytes != 0;
            return;
        end
        // one space for a collapsed run between kept characters
        if (pend_space && kept_bytes != 0) begin
            if (kept_chars >= lim_chars || kept_bytes + 1 >= cap) begin
                stopped = 1'b1;
                return;
            end
            owe_byte(8'h20);
            kept_bytes++;
            kept_chars++;
        end
        pend_space = 1'b0;
        if (kept_chars >= lim_chars || kept_bytes + width >= cap) begin
            stopped = 1'b1;
            return;
        end
        for (i = 0; i < width && i < 4; i++)
            owe_byte(seq_buf[i]);
        kept_bytes += width;
        kept_chars++;
    endfunction

    // strict utf-8 decode of one byte
    function automatic void decode_byte(logic [BYTE_W-1:0] b);
        int unsigned cp;
        int unsigned i;
        int unsigned width;
        logic [BYTE_W-1:0] lead;
        // lead byte
        if (seq_need == 0 || seq_have == 0) begin
            seq_buf[0] = b;
            seq_have   = 1;
            if (b < 8'h80) begin
                seq_need = 0;
                seq_have = 0;
                keep_char(b, 1);
                return;
            end
            if (b >= 8'hc2 && b <= 8'hdf)
                seq_need = 1;
            else if (b >= 8'he0 && b <= 8'hef)
                seq_need = 2;
            else if (b >= 8'hf0 && b <= 8'hf4)
                seq_need = 3;
            else begin
                failed   = 1'b1;
                seq_have = 0;
                seq_need = 0;
            end
            return;
        end
        // continuation byte
        if ((b & 8'hc0) != 8'h80) begin
            failed   = 1'b1;
            seq_have = 0;
            seq_need = 0;
            return;
        end
        seq_buf[seq_have & 3] = b;
        seq_have++;
        if (seq_have < seq_need + 1)
            return;
        // sequence complete: assemble and range check
        lead = seq_buf[0];
        if (seq_need == 1)
            cp = lead & 8'h1f;
        else if (seq_need == 2)
            cp = lead & 8'h0f;
        else
            cp = lead & 8'h07;
        for (i = 1; i <= seq_need && i < 4; i++)
            cp = (cp << 6) | (seq_buf[i] & 8'h3f);
        width    = seq_need + 1;
        seq_have = 0;
        seq_need = 0;
        if ((lead == 8'he0 && cp < 'h800) || (lead == 8'hed && cp >= 'hd800) ||
            (lead == 8'hf0 && cp < 'h10000) || cp > 'h10ffff) begin
            failed = 1'b1;
            return;
        end
        keep_char(cp, width);
    endfunction

    // one accepted request: text bytes, then the status at the end of a string
    function automatic void normalize_step(logic [BYTE_W-1:0] b, logic is_last);
        out_item_t item;
        status_t   st;
        if (!failed && !stopped)
            decode_byte(b);
        if (is_last) begin
            if (!failed && !stopped && seq_have != 0)
                failed = 1'b1;
            if (failed)
                st = STATUS_INVALID;
            else if (kept_chars >= 2)
                st = STATUS_OK;
            else
                st = STATUS_SHORT;
            item.out_byte  = '0;
            item.is_status = 1'b1;
            item.status    = st;
            item.out_last  = 1'b1;
            norm_text_q.push_back(item);
            case (st)
                STATUS_OK:      ok_count++;
                STATUS_INVALID: invalid_count++;
                default:        short_count++;
            endcase
            strings_done++;
            clear_text_state();
        end
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // watch all three channels
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lim_chars = CHAR_LIMIT_RST;
            lim_bytes = BYTE_CAP_RST;
            clear_text_state();
            norm_text_q.delete();
            fail_count    = 0;
            text_backlog  = 0;
            strings_done  = 0;
            bytes_in      = 0;
            bytes_out     = 0;
            ok_count      = 0;
            invalid_count = 0;
            short_count   = 0;
        end
        else begin
            // input request uses the registers as they stood before this edge
            if (in_valid && !in_stall) begin
                normalize_step(in_data.in_byte, in_data.in_last);
                bytes_in++;
            end
            // register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CHAR_LIMIT:    lim_chars = cfg_data[CHAR_LIMIT_W-1:0];
                    REG_BYTE_CAPACITY: lim_bytes = cfg_data[BYTE_CAP_W-1:0];
                    default: ;
                endcase
            end
            // output request against the oldest owed item
            if (out_valid && !out_stall) begin
                if (norm_text_q.size() == 0) begin
                    $display("%0t: unexpected output, expected nothing, got byte 0x%0h status %0d",
                             $time, out_data.out_byte, out_data.status);
                    fail_count++;
                end
                else begin
                    want = norm_text_q.pop_front();
                    check_field("out_byte", want.out_byte, out_data.out_byte);
                    check_field("is_status", want.is_status, out_data.is_status);
                    check_field("status", want.status, out_data.status);
                    check_field("out_last", want.out_last, out_data.out_last);
                    if (!want.is_status)
                        bytes_out++;
                end
            end
            text_backlog = norm_text_q.size();
        end
    end

endmodule

>>> tb/tb_utf8_text_normalizer.sv
// testbench top for the utf8 text normalizer: stimulus, receiver and verdict
module tb_utf8_text_normalizer;
    import utf8n_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int text_backlog;
    int strings_done;
    int bytes_in;
    int bytes_out;
    int ok_count;
    int invalid_count;
    int short_count;

    // string under construction
    logic [7:0] text_q [$];
    // no idling on either side while set
    bit quiet = 1'b0;
    // asks the receiver for a long hold-off
    bit hold_req = 1'b0;
    int hold_left = 0;

    // phase settings: char_limit and byte_capacity
    int unsigned phase_chars [8] = '{128, 255, 1, 3, 255, 5, 2, 64};
    int unsigned phase_caps  [8] = '{512, 512, 2, 1023, 8, 16, 3, 40};

    always #10 clk = ~clk;

    utf8_text_normalizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    utf8n_text_checker u_text_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .text_backlog  (text_backlog),
        .strings_done  (strings_done),
        .bytes_in      (bytes_in),
        .bytes_out     (bytes_out),
        .ok_count      (ok_count),
        .invalid_count (invalid_count),
        .short_count   (short_count)
    );

    // one input request, held until accepted
    task automatic send_byte(logic [7:0] b, logic is_last);
        in_item_t item;
        item.in_byte = b;
        item.in_last = is_last;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every owed result is out, then let the pipe empty
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (text_backlog != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // utf-8 encode one code point onto the string
    function automatic void put_cp(int unsigned cp);
        if (cp < 'h80)
            text_q.push_back(8'(cp));
        else if (cp < 'h800) begin
            text_q.push_back(8'(8'hc0 | (cp >> 6)));
            text_q.push_back(8'(8'h80 | (cp & 'h3f)));
        end
        else if (cp < 'h10000) begin
            text_q.push_back(8'(8'he0 | (cp >> 12)));
            text_q.push_back(8'(8'h80 | ((cp >> 6) & 'h3f)));
            text_q.push_back(8'(8'h80 | (cp & 'h3f)));
        end
        else begin
            text_q.push_back(8'(8'hf0 | (cp >> 18)));
            text_q.push_back(8'(8'h80 | ((cp >> 12) & 'h3f)));
            text_q.push_back(8'(8'h80 | ((cp >> 6) & 'h3f)));
            text_q.push_back(8'(8'h80 | (cp & 'h3f)));
        end
    endfunction

    function automatic logic [7:0] tail_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // any whitespace code point
    function automatic void put_blank();
        case ($urandom_range(0, 9))
            0: put_cp('h20);
            1: put_cp('h09);
            2: put_cp('h0a);
            3: put_cp('h0d);
            4: put_cp('h85);
            5: put_cp('ha0);
            6: put_cp('h1680);
            7: put_cp('h2000 + $urandom_range(0, 10));
            8: begin
                case ($urandom_range(0, 3))
                    0: put_cp('h2028);
                    1: put_cp('h2029);
                    2: put_cp('h202f);
                    default: put_cp('h205f);
                endcase
            end
            default: put_cp('h3000);
        endcase
    endfunction

    // well-formed character of any width, mostly printable
    function automatic void put_random_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            put_cp($urandom_range('h21, 'h7e));
        else if (r < 60)
            put_blank();
        else if (r < 70)
            put_cp($urandom_range('h80, 'h7ff));
        else if (r < 80)
            put_cp($urandom_range(0, 1) ? $urandom_range('h800, 'hd7ff)
                                        : $urandom_range('he000, 'hffff));
        else if (r < 88)
            put_cp($urandom_range('h10000, 'h10ffff));
        else begin
            case ($urandom_range(0, 2))
                0: put_cp($urandom_range('h01, 'h1f));
                1: put_cp('h7f);
                default: put_cp($urandom_range('h80, 'h9f));
            endcase
        end
    endfunction

    // random string; a noisy one carries one broken piece
    function automatic void build_random_text(bit noisy);
        int unsigned nchars;
        int unsigned kind;
        int unsigned brk;
        int unsigned i;
        nchars = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        kind   = $urandom_range(0, 6);
        // truncated sequences always sit at the end of the string
        brk    = !noisy ? nchars + 1 : (kind == 6) ? nchars : $urandom_range(0, nchars);
        for (i = 0; i <= nchars; i++) begin
            if (i == brk) begin
                case (kind)
                    0: text_q.push_back(8'($urandom_range(0, 255)));
                    1: text_q.push_back(tail_byte());
                    // overlong forms
                    2: begin
                        case ($urandom_range(0, 2))
                            0: begin
                                text_q.push_back(8'hc0 | 8'($urandom_range(0, 1)));
                                text_q.push_back(tail_byte());
                            end
                            1: begin
                                text_q.push_back(8'he0);
                                text_q.push_back(8'h80 | 8'($urandom_range(0, 31)));
                                text_q.push_back(tail_byte());
                            end
                            default: begin
                                text_q.push_back(8'hf0);
                                text_q.push_back(8'h80 | 8'($urandom_range(0, 15)));
                                text_q.push_back(tail_byte());
                                text_q.push_back(tail_byte());
                            end
                        endcase
                    end
                    // surrogate
                    3: begin
                        text_q.push_back(8'hed);
                        text_q.push_back(8'ha0 | 8'($urandom_range(0, 31)));
                        text_q.push_back(tail_byte());
                    end
                    // above the code space
                    4: begin
                        if ($urandom_range(0, 1)) begin
                            text_q.push_back(8'hf4);
                            text_q.push_back(8'($urandom_range('h90, 'hbf)));
                            text_q.push_back(tail_byte());
                            text_q.push_back(tail_byte());
                        end
                        else
                            text_q.push_back(8'($urandom_range('hf5, 'hff)));
                    end
                    // lead byte followed by a non-continuation
                    5: begin
                        text_q.push_back(8'he2);
                        text_q.push_back(8'($urandom_range('h21, 'h7e)));
                    end
                    default: begin
                        case ($urandom_range(0, 2))
                            0: text_q.push_back(8'($urandom_range('hc2, 'hdf)));
                            1: begin
                                text_q.push_back(8'he1);
                                text_q.push_back(tail_byte());
                            end
                            default: begin
                                text_q.push_back(8'hf1);
                                text_q.push_back(tail_byte());
                                text_q.push_back(tail_byte());
                            end
                        endcase
                    end
                endcase
            end
            if (i < nchars)
                put_random_char();
        end
    endfunction

    // receiver: random stalls, or a long hold-off on request
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left != 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet && ($urandom_range(0, 99) < 16);
        end
    end

    // stimulus and verdict
    initial begin
        int p;
        int sent;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CHAR_LIMIT;
        cfg_data  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // directed strings at reset settings
        // leading and trailing whitespace, a zero byte, a tab and lf run
        text_q = '{8'h20, 8'h00, 8'h61, 8'h09, 8'h0a, 8'h62, 8'h20};
        send_text();
        // bad lead byte, the rest of the string ignored
        text_q = '{8'hff, 8'h78};
        send_text();
        // only a control character: too short
        text_q = '{8'h01};
        send_text();
        // truncated at the last byte
        text_q = '{8'he2, 8'h82};
        send_text();
        // four byte character then ascii
        text_q = '{8'hf0, 8'h9f, 8'h98, 8'h80, 8'h7a};
        send_text();
        // surrogate
        text_q = '{8'hed, 8'ha0, 8'h80};
        send_text();

        // stop at the character limit, then a bad byte that goes unchecked
        settle();
        write_reg(REG_CHAR_LIMIT, 10'd1);
        text_q = '{8'h61, 8'h62, 8'hff};
        send_text();
        // limits too small for any character
        settle();
        write_reg(REG_CHAR_LIMIT, 10'd0);
        text_q = '{8'h71};
        send_text();
        settle();
        write_reg(REG_CHAR_LIMIT, 10'd255);
        write_reg(REG_BYTE_CAPACITY, 10'd1);
        text_q = '{8'h71};
        send_text();

        // random strings under each setting
        for (p = 0; p < 8; p++) begin
            settle();
            write_reg(REG_CHAR_LIMIT, 10'(phase_chars[p]));
            write_reg(REG_BYTE_CAPACITY, 10'(phase_caps[p]));
            quiet = (p == 1);
            if (p == 0)
                hold_req = 1'b1;
            sent = 0;
            while (sent < 36) begin
                build_random_text($urandom_range(0, 3) == 0);
                sent += text_q.size();
                send_text();
            end
        end
        quiet = 1'b0;
        settle();

        $display("covered %0d strings, %0d bytes in, %0d text bytes out", strings_done,
                 bytes_in, bytes_out);
        $display("status seen: %0d ok, %0d invalid, %0d too short", ok_count,
                 invalid_count, short_count);
        if (fail_count == 0 && text_backlog == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> utf8_text_normalizer.f
src/utf8n_pkg.sv
src/utf8n_core.sv
src/utf8n_serializer.sv
src/utf8_text_normalizer.sv
tb/utf8n_text_checker.sv
tb/tb_utf8_text_normalizer.sv
